@@ rtl/core/hsv_to_rgb_converter_assert.svh @@
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Check that holds outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while reset is asserted.
`define HSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

  localparam int unsigned PctW    = 7;
  localparam int unsigned HueW    = 10;
  localparam int unsigned OffsW   = 6;
  localparam int unsigned QHueW   = 5;
  localparam int unsigned SvW     = 14;
  // Channel numerators in units of 1/600000 of full scale
  localparam int unsigned XW      = 20;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;

  localparam logic [PctW-1:0] PctMax = 7'd100;

  // hue / 60 == (hue * 1093) >> 16 for every 10-bit hue
  localparam logic [10:0]  Hue60Recip = 11'd1093;
  localparam int unsigned  Hue60Shift = 16;

  // 600000 = 64 * 9375; half of 600000 over 64, rounded down
  localparam int unsigned DivC       = 9375;
  localparam int unsigned RoundC     = 4687;
  localparam int unsigned RoundShift = 6;

  localparam int unsigned NvScale  = 6000;
  localparam int unsigned NminStep = 60;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSaturation = 2'd0,
    CfgBrightness = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e          sector;
    logic [OffsW-1:0] offs;
  } item_t;

endpackage

@@ rtl/core/hsv2rgb_front.sv @@
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [HueW-1:0] hue_deg_i,
  output logic            full_o,
  input  logic            fifo_full_i,
  output logic            fifo_push_o,
  output item_t           fifo_item_o
);

  logic [HueW+10:0]  hmul;
  logic [QHueW-1:0]  q60;
  logic [HueW-1:0]   q60x;
  logic [HueW-1:0]   offs_full;
  logic [QHueW-1:0]  sec_raw;
  item_t             item_d;
  item_t             fr_item_q;
  logic              fr_valid_q, fr_valid_d;
  logic              accept;

  always_comb begin
    hmul      = (HueW+11)'(hue_deg_i) * (HueW+11)'(Hue60Recip);
    q60       = hmul[Hue60Shift +: QHueW];
    // 60*q as 64*q - 4*q; wraps harmlessly, true product stays below 1024
    q60x      = (HueW'(q60) << 6) - (HueW'(q60) << 2);
    offs_full = hue_deg_i - q60x;
    if (q60 >= QHueW'(12)) begin
      sec_raw = q60 - QHueW'(12);
    end else if (q60 >= QHueW'(6)) begin
      sec_raw = q60 - QHueW'(6);
    end else begin
      sec_raw = q60;
    end
    item_d.sector = sector_e'(sec_raw[2:0]);
    item_d.offs   = offs_full[OffsW-1:0];
  end

  assign fifo_push_o = fr_valid_q && !fifo_full_i;
  assign full_o      = fr_valid_q && fifo_full_i;
  assign fifo_item_o = fr_item_q;
  assign accept      = push_i && !full_o;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (fifo_push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_item_q <= item_d;
    end
  end

endmodule

@@ rtl/core/hsv2rgb_fifo.sv @@
module hsv2rgb_fifo import hsv2rgb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   count_q;

  assign full_o  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/hsv2rgb_back.sv @@
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_back import hsv2rgb_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [PctW-1:0]        sat_pct_i,
  input  logic [PctW-1:0]        bri_pct_i,
  input  logic                   fifo_empty_i,
  input  item_t                  fifo_item_i,
  output logic                   fifo_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [OUT_FRAC_BITS:0] red_frac_o,
  output logic [OUT_FRAC_BITS:0] green_frac_o,
  output logic [OUT_FRAC_BITS:0] blue_frac_o
);

  localparam int unsigned QW  = OUT_FRAC_BITS + 1;
  localparam int unsigned YW  = OUT_FRAC_BITS + 14;
  localparam int unsigned MW  = OUT_FRAC_BITS + 1;
  localparam int unsigned PW  = YW + MW;
  localparam int unsigned CW  = QW + 14;
  localparam int unsigned ShW = OUT_FRAC_BITS - RoundShift;
  localparam longint unsigned RecipFull = (64'd1 << YW) / 64'(DivC);
  localparam logic [MW-1:0] RecipM  = MW'(RecipFull);
  localparam logic [QW-1:0] CodeOne = QW'(1) << OUT_FRAC_BITS;

  logic [PctW-1:0] sat_c, bri_c;
  logic [SvW-1:0]  sv_d, sv_q;
  logic [XW-1:0]   nv_d, nv_q, nmin_d, nmin_q;

  logic [XW-1:0]   na, ninc, ndec;
  logic [2:0][XW-1:0] x1_d, x1_q;
  logic [2:0][YW-1:0] y2_d, y2_q;
  logic [2:0][QW-1:0] q02_d, q02_q;
  logic [2:0][YW-1:0] rem_s;
  logic [2:0][QW-1:0] out_d, out_q;
  logic v1_q, v2_q, v3_q;
  logic adv;

  // Settings-derived terms, refreshed every cycle
  always_comb begin
    sat_c  = (sat_pct_i > PctMax) ? PctMax : sat_pct_i;
    bri_c  = (bri_pct_i > PctMax) ? PctMax : bri_pct_i;
    sv_d   = SvW'(sat_c) * SvW'(bri_c);
    nv_d   = XW'(bri_c) * XW'(NvScale);
    nmin_d = nv_d - XW'(sv_d) * XW'(NminStep);
  end

  always_ff @(posedge clk_i) begin
    sv_q   <= sv_d;
    nv_q   <= nv_d;
    nmin_q <= nmin_d;
  end

  assign adv        = !v3_q || pop_i;
  assign fifo_pop_o = adv && !fifo_empty_i;
  assign empty_o    = !v3_q;

  // Stage 1: ramp term and sector routing
  always_comb begin
    na   = XW'(sv_q) * XW'(fifo_item_i.offs);
    ninc = nmin_q + na;
    ndec = nv_q - na;
    unique case (fifo_item_i.sector)
      SecRedYel: x1_d = {nmin_q, ninc,   nv_q};
      SecYelGrn: x1_d = {nmin_q, nv_q,   ndec};
      SecGrnCyn: x1_d = {ninc,   nv_q,   nmin_q};
      SecCynBlu: x1_d = {nv_q,   ndec,   nmin_q};
      SecBluMag: x1_d = {nv_q,   nmin_q, ninc};
      default:   x1_d = {ndec,   nmin_q, nv_q};
    endcase
  end

  // Stages 2 and 3: divide by 600000 with rounding, per channel
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [PW-1:0] prod;
    logic [CW-1:0] back_prod;

    always_comb begin
      y2_d[c]   = {x1_q[c], {ShW{1'b0}}} + YW'(RoundC);
      prod      = PW'(y2_d[c]) * PW'(RecipM);
      q02_d[c]  = prod[YW +: QW];
      back_prod = CW'(q02_q[c]) * CW'(DivC);
      rem_s[c]  = y2_q[c] - back_prod[YW-1:0];
      // estimate is low by at most one
      out_d[c]  = q02_q[c] + QW'(rem_s[c] >= YW'(DivC));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !fifo_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q  <= x1_d;
      y2_q  <= y2_d;
      q02_q <= q02_d;
      out_q <= out_d;
    end
  end

  assign red_frac_o   = out_q[0];
  assign green_frac_o = out_q[1];
  assign blue_frac_o  = out_q[2];

  `HSV_ASSERT(a_code_range, v3_q |-> (out_q[0] <= CodeOne) && (out_q[1] <= CodeOne) && (out_q[2] <= CodeOne), "channel code above full scale")
  `HSV_ASSERT(a_quot_est, v2_q |-> (rem_s[0] < YW'(2*DivC)) && (rem_s[1] < YW'(2*DivC)) && (rem_s[2] < YW'(2*DivC)), "quotient estimate off by more than one")
  `HSV_ASSERT(a_stall_hold, v3_q && v2_q && !pop_i |=> v3_q && v2_q && $stable(y2_q) && $stable(q02_q), "pipeline moved while output stalled")
  `HSV_ASSERT_RST(a_reset_empty, !rst_ni |=> !v1_q && !v2_q && !v3_q, "pipeline holds an item in reset")

endmodule

@@ rtl/core/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: each hue in degrees (wrapping modulo 360) becomes red, green and
// blue codes with OUT_FRAC_BITS fraction bits, where 2^OUT_FRAC_BITS means 1.0, rounded
// to nearest with ties up, using the saturation and brightness percentages in config
// registers 0 and 1 (values above 100 act as 100). One item per clock is taken and
// delivered while pop keeps up; the rate is set by the three-stage conversion pipeline,
// which advances whenever its output register is free or being popped. A taken item passes
// the hue classifier register, then an entry of the four-entry queue, then the pipeline's
// ramp, quotient-estimate and result registers before its result appears. Change the
// registers only while no item is in flight.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [HueW-1:0]        hue_deg_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [OUT_FRAC_BITS:0] red_frac_o,
  output logic [OUT_FRAC_BITS:0] green_frac_o,
  output logic [OUT_FRAC_BITS:0] blue_frac_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [PctW-1:0]        cfg_data_i
);

  logic [PctW-1:0] sat_q, bri_q;
  logic            fifo_full, fifo_push, fifo_empty, fifo_pop;
  item_t           front_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= PctMax;
      bri_q <= PctMax;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSaturation: sat_q <= cfg_data_i;
        CfgBrightness: bri_q <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .hue_deg_i   (hue_deg_i),
    .full_o      (full),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_item_o (front_item)
  );

  hsv2rgb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .item_o  (head_item)
  );

  hsv2rgb_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sat_pct_i    (sat_q),
    .bri_pct_i    (bri_q),
    .fifo_empty_i (fifo_empty),
    .fifo_item_i  (head_item),
    .fifo_pop_o   (fifo_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .red_frac_o   (red_frac_o),
    .green_frac_o (green_frac_o),
    .blue_frac_o  (blue_frac_o)
  );

endmodule
